// ===== design/sle_pkg.sv =====
`default_nettype none

package sle_pkg;

   localparam int CAPACITY_DEF = 16;

   typedef enum logic [2:0] {
      OP_INSERT    = 3'd0,
      OP_DEL_FIRST = 3'd1,
      OP_DEL_LAST  = 3'd2,
      OP_DEL_AFTER = 3'd3,
      OP_DEL_KEY   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_EMPTY   = 3'd1,
      ST_FULL    = 3'd2,
      ST_NOKEY   = 3'd3,
      ST_NOAFTER = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_FINISH,
      S_RESPOND
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic signed [31:0] value;
   } req_beat_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] removed_value;
      logic [4:0]         entry_count;
      logic signed [31:0] smallest;
      logic signed [31:0] largest;
   } rsp_beat_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_scan;
      logic scan_done;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== design/sle_ram.sv =====
`default_nettype none

module sle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sle_ctrl.sv =====
`default_nettype none

module sle_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sle_pkg::ctrl_cmd_type cmd,
   input  sle_pkg::dp_stat_type  stat
);

   import sle_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = stat.need_scan ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_RESPOND;
         end
         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/sle_datapath.sv =====
`default_nettype none

module sle_datapath #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sle_pkg::ctrl_cmd_type cmd,
   output sle_pkg::dp_stat_type  stat,
   input  sle_pkg::req_beat_type req_data,
   output sle_pkg::rsp_beat_type rsp_data
);

   import sle_pkg::*;

   localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int ExtW = CntW + 5;
   localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);
   localparam logic [CntW-1:0] CntOne  = CntW'(1);

   logic [2:0]         op_ff, op_in;
   logic signed [31:0] key_ff, key_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic signed [31:0] head_ff, head_in;
   logic signed [31:0] tail_ff, tail_in;
   logic [CntW-1:0]    rd_cnt_ff, rd_cnt_in;
   logic               pipe_vld_ff, pipe_vld_in;
   logic [CntW-1:0]    pipe_idx_ff, pipe_idx_in;
   logic               found_ff, found_in;
   logic               match_ff, match_in;
   logic               placed_ff, placed_in;
   logic               head_set_ff, head_set_in;
   logic signed [31:0] carry_ff, carry_in;
   logic signed [31:0] removed_ff, removed_in;
   logic signed [31:0] new_head_ff, new_head_in;
   logic signed [31:0] new_tail_ff, new_tail_in;
   rsp_beat_type       res_ff, res_in;
   rsp_beat_type       out_ff, out_in;

   logic               ram_wr_en;
   logic [IdxW-1:0]    ram_wr_addr;
   logic signed [31:0] ram_wr_data;
   logic               ram_rd_en;
   logic [IdxW-1:0]    ram_rd_addr;
   logic [31:0]        ram_rd_data;

   logic signed [31:0] datum;
   logic [CntW-1:0]    idx_prev;
   logic [CntW-1:0]    cnt_new;
   logic [ExtW-1:0]    cnt_ext;
   logic               last_beat;
   logic               target;
   logic               is_delete;

   sle_ram #(
      .WIDTH(32),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      op_in       = op_ff;
      key_in      = key_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      rd_cnt_in   = rd_cnt_ff;
      pipe_vld_in = 1'b0;
      pipe_idx_in = rd_cnt_ff;
      found_in    = found_ff;
      match_in    = match_ff;
      placed_in   = placed_ff;
      head_set_in = head_set_ff;
      carry_in    = carry_ff;
      removed_in  = removed_ff;
      new_head_in = new_head_ff;
      new_tail_in = new_tail_ff;
      res_in      = res_ff;
      out_in      = out_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = '0;
      ram_wr_data = key_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_cnt_ff[IdxW-1:0];
      datum       = $signed(ram_rd_data);
      idx_prev    = pipe_idx_ff - CntOne;
      cnt_new     = count_ff;
      cnt_ext     = '0;
      last_beat   = (pipe_idx_ff + CntOne) == count_ff;
      target      = 1'b0;
      is_delete   = (op_ff == OP_DEL_FIRST) || (op_ff == OP_DEL_LAST) ||
                    (op_ff == OP_DEL_AFTER) || (op_ff == OP_DEL_KEY);

      if (cmd.load) begin
         op_in       = req_data.req_type;
         key_in      = req_data.value;
         rd_cnt_in   = '0;
         found_in    = 1'b0;
         match_in    = 1'b0;
         placed_in   = 1'b0;
         head_set_in = 1'b0;
      end

      if (cmd.scan && (rd_cnt_ff < count_ff)) begin
         ram_rd_en   = 1'b1;
         rd_cnt_in   = rd_cnt_ff + CntOne;
         pipe_vld_in = 1'b1;
      end

      // Inserts ripple a carried entry upward; deletes pull entries down over the gap.
      if (pipe_vld_ff) begin
         if (op_ff == OP_INSERT) begin
            if (placed_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pipe_idx_ff[IdxW-1:0];
               ram_wr_data = carry_ff;
               carry_in    = datum;
            end else if (datum >= key_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pipe_idx_ff[IdxW-1:0];
               ram_wr_data = key_ff;
               carry_in    = datum;
               placed_in   = 1'b1;
            end
         end else begin
            case (op_ff)
               OP_DEL_FIRST: target = !found_ff && (pipe_idx_ff == '0);
               OP_DEL_LAST:  target = last_beat;
               OP_DEL_AFTER: target = !found_ff && match_ff;
               OP_DEL_KEY:   target = !found_ff && (datum == key_ff);
               default:      target = 1'b0;
            endcase
            if ((op_ff == OP_DEL_AFTER) && !found_ff && !match_ff && (datum == key_ff)) begin
               match_in = 1'b1;
            end
            if (target) begin
               found_in   = 1'b1;
               removed_in = datum;
            end else begin
               if (found_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_prev[IdxW-1:0];
                  ram_wr_data = datum;
               end
               if (!head_set_ff) begin
                  new_head_in = datum;
                  head_set_in = 1'b1;
               end
               new_tail_in = datum;
            end
         end
      end

      if (cmd.finish) begin
         res_in.status        = ST_DONE;
         res_in.removed_value = '0;
         case (op_ff)
            OP_INSERT: begin
               if (count_ff == CntFull) begin
                  res_in.status = ST_FULL;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = count_ff[IdxW-1:0];
                  ram_wr_data = placed_ff ? carry_ff : key_ff;
                  cnt_new     = count_ff + CntOne;
                  if ((count_ff == '0) || (key_ff <= head_ff)) begin
                     head_in = key_ff;
                  end
                  if ((count_ff == '0) || (key_ff > tail_ff)) begin
                     tail_in = key_ff;
                  end
               end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AFTER, OP_DEL_KEY: begin
               if (count_ff == '0) begin
                  res_in.status = ST_EMPTY;
               end else if (found_ff) begin
                  cnt_new              = count_ff - CntOne;
                  res_in.removed_value = removed_ff;
                  head_in              = new_head_ff;
                  tail_in              = new_tail_ff;
               end else if ((op_ff == OP_DEL_AFTER) && match_ff) begin
                  res_in.status = ST_NOAFTER;
               end else begin
                  res_in.status = ST_NOKEY;
               end
            end
            default: begin
               res_in.status = ST_DONE;
            end
         endcase
         count_in           = cnt_new;
         cnt_ext            = ExtW'(cnt_new);
         res_in.entry_count = cnt_ext[4:0];
         res_in.smallest    = (cnt_new == '0) ? 32'sd0 : head_in;
         res_in.largest     = (cnt_new == '0) ? 32'sd0 : tail_in;
      end

      if (cmd.out_load) begin
         out_in = res_ff;
      end

      stat.need_scan = (count_ff != '0) &&
                       (((op_ff == OP_INSERT) && (count_ff != CntFull)) || is_delete);
      stat.scan_done = pipe_vld_ff && last_beat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         rd_cnt_ff   <= '0;
         pipe_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         match_ff    <= 1'b0;
         placed_ff   <= 1'b0;
         head_set_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         rd_cnt_ff   <= rd_cnt_in;
         pipe_vld_ff <= pipe_vld_in;
         found_ff    <= found_in;
         match_ff    <= match_in;
         placed_ff   <= placed_in;
         head_set_ff <= head_set_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      pipe_idx_ff <= pipe_idx_in;
      carry_ff    <= carry_in;
      removed_ff  <= removed_in;
      new_head_ff <= new_head_in;
      new_tail_ff <= new_tail_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
   end

   assign rsp_data = out_ff;

endmodule

`default_nettype wire

// ===== design/sorted_list_engine_core.sv =====
`default_nettype none

// Channel   Direction  Handshake              Beat
// req       in         req_valid/req_ready    req_data (request type, value or key)
// rsp       out        rsp_valid/rsp_ready    rsp_data (status, removed, count, ends)
//
// A request that needs no walk of the store passes through the check, finish and respond states to its result.
// Any other request walks the held entries through the store's read port, one per cycle,
// and then finishes and responds in the same way.
// Synchronous reset empties the list; the store contents are not cleared.
// A result waits in the output register while the next request is accepted.

module sorted_list_engine_core #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sle_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sle_pkg::rsp_beat_type rsp_data
);

   import sle_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   sle_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .stat     (stat)
   );

   sle_datapath #(
      .CAPACITY(CAPACITY)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .stat    (stat),
      .req_data(req_data),
      .rsp_data(rsp_data)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && !rsp_ready))
      else $error("pending result overwritten");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == ST_EMPTY)) |->
      ((rsp_data.entry_count == 5'd0) && (rsp_data.smallest == 32'sd0) &&
       (rsp_data.largest == 32'sd0)))
      else $error("empty status with nonempty result");

   a_ends_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.smallest <= rsp_data.largest))
      else $error("smallest entry above largest entry");

endmodule

`default_nettype wire

// ===== tb/sv/sorted_list_engine_core_tb.sv =====
`timescale 1ns / 1ps

module sorted_list_engine_core_tb;
   import sle_pkg::*;

   localparam int CAPACITY = CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 400;
   localparam int QUIET_ITEMS = 60;
   localparam int SETTLE_CYCLES = 40;
   localparam longint RUN_LIMIT_NS = 4_000_000;
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST = 3'd7;
   localparam int INT_MAX = 32'sh7fffffff;
   localparam int INT_MIN = 32'sh80000000;

   class list_scoreboard;
      int held[$];
      rsp_beat_type outcomes[$];
      int failures;

      function new();
         failures = 0;
      endfunction

      function int pending();
         return outcomes.size();
      endfunction

      function void note_request(req_beat_type beat);
         rsp_beat_type outcome;
         int key;
         int pos;
         outcome = '0;
         outcome.status = ST_DONE;
         key = beat.value;
         pos = 0;
         case (beat.req_type)
            OP_INSERT: begin
               if (held.size() >= CAPACITY) begin
                  outcome.status = ST_FULL;
               end else begin
                  while (pos < held.size() && held[pos] < key) pos++;
                  held.insert(pos, key);
               end
            end
            OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AFTER, OP_DEL_KEY: begin
               if (held.size() == 0) begin
                  outcome.status = ST_EMPTY;
                  pos = -1;
               end else if (beat.req_type == OP_DEL_FIRST) begin
                  pos = 0;
               end else if (beat.req_type == OP_DEL_LAST) begin
                  pos = held.size() - 1;
               end else begin
                  while (pos < held.size() && held[pos] != key) pos++;
                  if (pos >= held.size()) begin
                     outcome.status = ST_NOKEY;
                     pos = -1;
                  end else if (beat.req_type == OP_DEL_AFTER) begin
                     if (pos + 1 >= held.size()) begin
                        outcome.status = ST_NOAFTER;
                        pos = -1;
                     end else begin
                        pos = pos + 1;
                     end
                  end
               end
               if (pos >= 0) begin
                  outcome.removed_value = held[pos];
                  held.delete(pos);
               end
            end
            default: begin
            end
         endcase
         outcome.entry_count = 5'(held.size());
         if (held.size() > 0) begin
            outcome.smallest = held[0];
            outcome.largest = held[held.size() - 1];
         end
         outcomes.push_back(outcome);
      endfunction

      function void check_result(rsp_beat_type got);
         rsp_beat_type want;
         if (outcomes.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: status %0d removed %0d count %0d min %0d max %0d",
                        got.status, got.removed_value, got.entry_count, got.smallest,
                        got.largest);
            return;
         end
         want = outcomes.pop_front();
         if (got.status !== want.status || got.removed_value !== want.removed_value ||
             got.entry_count !== want.entry_count || got.smallest !== want.smallest ||
             got.largest !== want.largest) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch: expected status %0d removed %0d count %0d min %0d max %0d",
                        want.status, want.removed_value, want.entry_count, want.smallest,
                        want.largest);
               $display("          actual   status %0d removed %0d count %0d min %0d max %0d",
                        got.status, got.removed_value, got.entry_count, got.smallest,
                        got.largest);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_beat_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_beat_type rsp_data;

   bit idle_on = 1'b1;
   int stall_left = 0;
   list_scoreboard sb = new();

   sorted_list_engine_core #(
      .CAPACITY(CAPACITY)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_request(input logic [2:0] op, input int val);
      req_beat_type beat;
      beat.req_type = op;
      beat.value = val;
      req_data <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic int pick_value();
      case ($urandom_range(0, 9))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0: return INT_MAX;
               1: return INT_MIN;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return $urandom_range(0, 15) - 8;
      endcase
   endfunction

   initial begin
      #(RUN_LIMIT_NS);
      $display("status: fail");
      $finish;
   end

   initial begin
      int n;
      int insert_pct;
      int roll;
      int key;
      logic [2:0] op;
      int fill_values[16] = '{INT_MAX, INT_MIN, 0, -1, 5, 5, 5, -7,
                              100, 3, 3, -100, 42, 1, 2, 7};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_DEL_FIRST, 0);
      send_request(OP_DEL_LAST, INT_MAX);
      send_request(OP_DEL_AFTER, INT_MIN);
      send_request(OP_DEL_KEY, -1);
      foreach (fill_values[i]) send_request(OP_INSERT, fill_values[i]);
      send_request(OP_INSERT, 9);
      send_request(OP_DEL_AFTER, INT_MAX);
      send_request(OP_DEL_KEY, 77);
      send_request(OP_DEL_AFTER, 77);
      send_request(OP_DEL_AFTER, INT_MIN);
      send_request(OP_DEL_KEY, 5);
      send_request(OP_DEL_FIRST, 0);
      send_request(OP_DEL_LAST, 0);
      for (op = OP_SPARE_FIRST; op <= OP_SPARE_LAST && op >= OP_SPARE_FIRST; op++)
         send_request(op, pick_value());

      drain_results();

      insert_pct = 50;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(0, 3))
               0: insert_pct = 25;
               1: insert_pct = 50;
               2: insert_pct = 75;
               default: insert_pct = 95;
            endcase
         end
         if (n == 150 || n == 300) drain_results();
         if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;

         roll = $urandom_range(0, 99);
         key = pick_value();
         if (roll < 3) begin
            op = OP_SPARE_FIRST + 3'($urandom_range(0, 2));
         end else if (roll < insert_pct) begin
            op = OP_INSERT;
         end else begin
            case ($urandom_range(0, 3))
               0: op = OP_DEL_FIRST;
               1: op = OP_DEL_LAST;
               2: op = OP_DEL_AFTER;
               default: op = OP_DEL_KEY;
            endcase
            if (sb.held.size() > 0 && $urandom_range(0, 9) < 7)
               key = sb.held[$urandom_range(0, sb.held.size() - 1)];
         end
         send_request(op, key);
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/sle_pkg.sv
design/sle_ram.sv
design/sle_ctrl.sv
design/sle_datapath.sv
design/sorted_list_engine_core.sv
tb/sv/sorted_list_engine_core_tb.sv
